// ----- sv/ucc_pkg.sv -----
// Shared types, constants and small tables for the Unix time calendar converter.
`timescale 1ns / 1ps

package ucc_pkg;

  // Register stages from the request port to the response port.
  localparam int UCC_STAGES = 15;

  typedef enum logic {
    UCC_OP_TO_SECONDS  = 1'b0,
    UCC_OP_TO_CALENDAR = 1'b1
  } ucc_op_t;

  // Valid range of seconds: 0001-01-01 00:00:00 through 9999-12-31 23:59:59.
  localparam logic signed [40:0] UCC_MIN_SEC = -41'sd62135596800;
  localparam logic signed [40:0] UCC_MAX_SEC = 41'sd253402300799;

  // 86400 * 3181458, just above 2^38; the multiplier is a multiple of 7.
  localparam logic [39:0] UCC_SEC_BIAS = 40'd274877971200;
  // Bias in days minus the day shift to 0000-03-01.
  localparam logic [23:0] UCC_DAY_SHIFT = 24'd2461990;
  // 1970 epoch minus the Julian day base, folded with the day-of-year offsets.
  localparam logic [24:0] UCC_JD_OFFSET = 25'd2472633;
  // Thursday offset plus a multiple of 7 that keeps the weekday sum positive.
  localparam logic [23:0] UCC_WDAY_BIAS = 24'd917507;

  // Reciprocals for division by constants: floor(x * M / 2^K).
  localparam logic [17:0] UCC_RCP_675_HI = 18'd198842;     // K = 27, x < 2^17
  localparam logic [26:0] UCC_RCP_675_LO = 27'd101806633;  // K = 36, x < 2^26
  localparam logic [15:0] UCC_RCP_100    = 16'd41944;      // K = 22, x < 2^15
  localparam logic [17:0] UCC_RCP_60_SOD = 18'd139811;     // K = 23, x < 2^17
  localparam logic [11:0] UCC_RCP_60_MIN = 12'd2185;       // K = 17, x < 2^11
  localparam logic [22:0] UCC_RCP_ERA    = 23'd7525902;    // K = 40, x < 2^22
  localparam logic [18:0] UCC_RCP_365    = 19'd367720;     // K = 27 (/365), K = 29 (/1460)
  localparam logic [9:0]  UCC_RCP_100_Y  = 10'd656;        // K = 16, x < 2^9
  localparam logic [14:0] UCC_RCP_153_5  = 15'd17135;      // 5 * 3427, K = 19
  localparam logic [12:0] UCC_RCP_153_2  = 13'd6854;       // 2 * 3427

  typedef struct packed {
    ucc_op_t            op;
    logic signed [38:0] epoch_seconds;
    logic [13:0]        year_in;
    logic [3:0]         month_in;
    logic [4:0]         day_in;
    logic [4:0]         hour_in;
    logic [5:0]         minute_in;
    logic [5:0]         second_in;
  } ucc_req_t;

  typedef struct packed {
    logic signed [38:0] seconds_out;
    logic [13:0]        year_out;
    logic [3:0]         month_out;
    logic [4:0]         day_out;
    logic [4:0]         hour_out;
    logic [5:0]         minute_out;
    logic [5:0]         second_out;
    logic [2:0]         weekday;
    logic               out_of_range;
  } ucc_rsp_t;

  // Days before the start of a month counted from March: (153 * m + 2) / 5.
  function automatic logic [8:0] ucc_mday_off(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      4'd12:   r = 9'd367;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Residue modulo 7 through octal digit sums (8 is 1 modulo 7).
  function automatic logic [2:0] ucc_mod7(input logic [24:0] x);
    logic [26:0] xp;
    logic [5:0]  s1;
    logic [3:0]  s2;
    logic [2:0]  r;
    xp = {2'b00, x};
    s1 = '0;
    for (int i = 0; i < 9; i++) begin
      s1 = s1 + 6'(xp[3*i +: 3]);
    end
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    if (s2 >= 4'd14) begin
      r = 3'(s2 - 4'd14);
    end else if (s2 >= 4'd7) begin
      r = 3'(s2 - 4'd7);
    end else begin
      r = s2[2:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/unix_time_calendar_converter_core.sv -----
// Top level of the Unix time calendar converter: ports, stage valids and flow control.
`timescale 1ns / 1ps

// Converts between signed Unix seconds and proleptic Gregorian date and time.
// With op = 0 the word's year, month, day, hour, minute and second become
// seconds since 1970-01-01 00:00:00; the date fields are not checked, so
// out-of-range values carry into their neighbors, and out_of_range flags a
// result outside years 1 to 9999 (seconds_out then holds the low 39 bits).
// With op = 1 epoch_seconds is split, flooring toward negative, into a day
// count and a time of day, and the day count into year, month and day; those
// three read 0 when the seconds lie outside years 1 to 9999. Both operations
// give the weekday, Monday = 0. One word enters per clock while req_stall is
// low: the converter is a 15-stage pipeline, each stage built from multiplies by
// constant reciprocals and wide adds, and a new word can follow every cycle
// unless the pipeline is full and stalled. The last stage is the
// output register; while it holds a stalled word, earlier stages keep moving
// into empty slots, and req_stall rises only once every stage is full.
module unix_time_calendar_converter_core (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_stall,
  input  logic               op,
  input  logic signed [38:0] epoch_seconds,
  input  logic [13:0]        year_in,
  input  logic [3:0]         month_in,
  input  logic [4:0]         day_in,
  input  logic [4:0]         hour_in,
  input  logic [5:0]         minute_in,
  input  logic [5:0]         second_in,
  // response channel
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [38:0] seconds_out,
  output logic [13:0]        year_out,
  output logic [3:0]         month_out,
  output logic [4:0]         day_out,
  output logic [4:0]         hour_out,
  output logic [5:0]         minute_out,
  output logic [5:0]         second_out,
  output logic [2:0]         weekday,
  output logic               out_of_range
);
  import ucc_pkg::*;

  logic [UCC_STAGES-1:0] vld;   // stage holds a live word
  logic [UCC_STAGES-1:0] adv;   // stage loads this cycle
  ucc_req_t              req;
  ucc_rsp_t              rsp;

  // A stage loads when it is empty or its word moves on; the output stage
  // moves on when the response is taken.
  always_comb begin
    adv[UCC_STAGES-1] = !vld[UCC_STAGES-1] || !rsp_stall;
    for (int k = UCC_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign req_stall = !adv[0];

  // Advance the valid bits with the data; bubbles are dropped as they fill.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= req_valid;
      end
      for (int k = 1; k < UCC_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Gather the request fields into one word.
  always_comb begin
    req.op            = ucc_op_t'(op);
    req.epoch_seconds = epoch_seconds;
    req.year_in       = year_in;
    req.month_in      = month_in;
    req.day_in        = day_in;
    req.hour_in       = hour_in;
    req.minute_in     = minute_in;
    req.second_in     = second_in;
  end

  ucc_datapath u_datapath (
    .clk (clk),
    .adv (adv),
    .req (req),
    .rsp (rsp)
  );

  // Drive the response from the output stage.
  assign rsp_valid    = vld[UCC_STAGES-1];
  assign seconds_out  = rsp.seconds_out;
  assign year_out     = rsp.year_out;
  assign month_out    = rsp.month_out;
  assign day_out      = rsp.day_out;
  assign hour_out     = rsp.hour_out;
  assign minute_out   = rsp.minute_out;
  assign second_out   = rsp.second_out;
  assign weekday      = rsp.weekday;
  assign out_of_range = rsp.out_of_range;

endmodule

// ----- sv/ucc_datapath.sv -----
// Staged arithmetic of the converter: both directions, one stage register per step.
`timescale 1ns / 1ps

module ucc_datapath (
  input  logic                                clk,
  input  logic [ucc_pkg::UCC_STAGES-1:0]      adv,
  input  ucc_pkg::ucc_req_t                   req,
  output ucc_pkg::ucc_rsp_t                   rsp
);
  import ucc_pkg::*;

  typedef struct {
    ucc_op_t            op;
    logic signed [38:0] secs_in;
    logic [13:0]        yr;
    logic [3:0]         mo;
    logic [4:0]         dy;
    logic [4:0]         hr;
    logic [5:0]         mi;
    logic [5:0]         se;
    // seconds to calendar
    logic               oor1;
    logic [32:0]        w;
    logic [6:0]         ulo;
    logic [34:0]        ph;
    logic [7:0]         qh;
    logic [9:0]         rh;
    logic [52:0]        pl;
    logic [15:0]        ql;
    logic [9:0]         rl;
    logic [16:0]        sod;
    logic [21:0]        z;
    logic [24:0]        wdarg;
    logic [34:0]        pm60;
    logic [44:0]        pera;
    logic [10:0]        m60;
    logic [2:0]         wday;
    logic [4:0]         era;
    logic [17:0]        doe;
    logic [22:0]        pmh;
    logic [5:0]         se1;
    logic [36:0]        p1460;
    logic [2:0]         cent;
    logic               lastd;
    logic [4:0]         hr1;
    logic [5:0]         mi1;
    logic [13:0]        era400;
    logic [17:0]        a;
    logic [36:0]        p365;
    logic [8:0]         yoe;
    logic [17:0]        yoe365;
    logic [18:0]        pyoe100;
    logic [8:0]         doy;
    logic [22:0]        pmp;
    // calendar to seconds
    logic [14:0]        yy;
    logic [8:0]         dfrac;
    logic [30:0]        p100;
    logic [22:0]        y365;
    logic [12:0]        sum1;
    logic signed [23:0] days0;
    logic signed [40:0] secp;
    logic [16:0]        hms;
    logic [24:0]        wd0;
    logic signed [40:0] secs0;
    logic               oor0;
    // result word
    ucc_rsp_t           res;
  } ucc_work_t;

  ucc_work_t st [UCC_STAGES];
  ucc_work_t nx [UCC_STAGES];

  logic [39:0] u;
  logic        early;
  logic [3:0]  mm;
  logic [7:0]  qh_c;
  logic [8:0]  c100;
  logic [25:0] v_hi;
  logic [25:0] v_lo;
  logic [15:0] ql_c;
  logic [16:0] sod_c;
  logic [23:0] q_c;
  logic [4:0]  era_c;
  logic [4:0]  hr1_c;
  logic [3:0]  mp;
  logic [3:0]  mon_c;
  logic [4:0]  day_c;
  logic [13:0] yr_c;

  always_comb begin
    // Stage 0: bias seconds to non-negative, check their range, set up the March-based year.
    nx[0]         = st[0];
    nx[0].op      = req.op;
    nx[0].secs_in = req.epoch_seconds;
    nx[0].yr      = req.year_in;
    nx[0].mo      = req.month_in;
    nx[0].dy      = req.day_in;
    nx[0].hr      = req.hour_in;
    nx[0].mi      = req.minute_in;
    nx[0].se      = req.second_in;
    u             = 40'(req.epoch_seconds) + UCC_SEC_BIAS;
    nx[0].w       = u[39:7];
    nx[0].ulo     = u[6:0];
    nx[0].oor1    = (41'(req.epoch_seconds) < UCC_MIN_SEC) ||
                    (41'(req.epoch_seconds) > UCC_MAX_SEC);
    early         = (req.month_in <= 4'd2);
    mm            = early ? 4'(req.month_in + 4'd9) : 4'(req.month_in - 4'd3);
    nx[0].yy      = 15'(req.year_in) + 15'd4800 - 15'(early);
    nx[0].dfrac   = ucc_mday_off(mm);

    // Stage 1: high digit of the divide by 675, year terms.
    nx[1]      = st[0];
    nx[1].ph   = 35'(st[0].w[32:16]) * 35'(UCC_RCP_675_HI);
    nx[1].p100 = 31'(st[0].yy) * 31'(UCC_RCP_100);
    nx[1].y365 = 23'(st[0].yy) * 23'd365;
    nx[1].sum1 = 13'(st[0].dy) + 13'(st[0].dfrac) + 13'(st[0].yy[14:2]);

    // Stage 2: high quotient and remainder, day count from the date.
    nx[2]       = st[1];
    qh_c        = st[1].ph[34:27];
    nx[2].qh    = qh_c;
    nx[2].rh    = 10'(17'(st[1].w[32:16]) - 17'(qh_c) * 17'd675);
    c100        = st[1].p100[30:22];
    nx[2].days0 = 24'(25'(st[1].y365) + 25'(st[1].sum1) - 25'(c100) + 25'(c100[8:2])
                      - UCC_JD_OFFSET);

    // Stage 3: low digit of the divide by 675, seconds of the day count, time of day, weekday sum.
    nx[3]      = st[2];
    v_hi       = {st[2].rh, st[2].w[15:0]};
    nx[3].pl   = 53'(v_hi) * 53'(UCC_RCP_675_LO);
    nx[3].secp = 41'(st[2].days0) * 41'sd86400;
    nx[3].hms  = 17'(st[2].hr) * 17'd3600 + 17'(st[2].mi) * 17'd60 + 17'(st[2].se);
    nx[3].wd0  = {1'b0, 24'(st[2].days0 + $signed(UCC_WDAY_BIAS))};

    // Stage 4: low quotient and remainder, full seconds.
    nx[4]       = st[3];
    v_lo        = {st[3].rh, st[3].w[15:0]};
    ql_c        = st[3].pl[51:36];
    nx[4].ql    = ql_c;
    nx[4].rl    = 10'(v_lo - 26'(ql_c) * 26'd675);
    nx[4].secs0 = st[3].secp + $signed(41'(st[3].hms));

    // Stage 5: day count and second of day, range check of the computed seconds.
    nx[5]       = st[4];
    sod_c       = {st[4].rl, st[4].ulo};
    q_c         = {st[4].qh, st[4].ql};
    nx[5].sod   = sod_c;
    nx[5].z     = 22'(q_c - UCC_DAY_SHIFT);
    nx[5].wdarg = (st[4].op == UCC_OP_TO_CALENDAR) ? 25'(q_c) + 25'd3 : st[4].wd0;
    nx[5].pm60  = 35'(sod_c) * 35'(UCC_RCP_60_SOD);
    nx[5].oor0  = (st[4].secs0 < UCC_MIN_SEC) || (st[4].secs0 > UCC_MAX_SEC);

    // Stage 6: 400-year era, minutes of day, weekday.
    nx[6]      = st[5];
    nx[6].pera = 45'(st[5].z) * 45'(UCC_RCP_ERA);
    nx[6].m60  = st[5].pm60[33:23];
    nx[6].wday = ucc_mod7(st[5].wdarg);

    // Stage 7: day of era, split the minutes.
    nx[7]      = st[6];
    era_c      = st[6].pera[44:40];
    nx[7].era  = era_c;
    nx[7].doe  = 18'(st[6].z - 22'(era_c) * 22'd146097);
    nx[7].pmh  = 23'(st[6].m60) * 23'(UCC_RCP_60_MIN);
    nx[7].se1  = 6'(st[6].sod - 17'(st[6].m60) * 17'd60);

    // Stage 8: leap corrections of the day of era, hour and minute.
    nx[8]        = st[7];
    nx[8].p1460  = 37'(st[7].doe) * 37'(UCC_RCP_365);
    nx[8].cent   = 3'(st[7].doe >= 18'd36524) + 3'(st[7].doe >= 18'd73048) +
                   3'(st[7].doe >= 18'd109572) + 3'(st[7].doe >= 18'd146096);
    nx[8].lastd  = (st[7].doe >= 18'd146096);
    hr1_c        = st[7].pmh[21:17];
    nx[8].hr1    = hr1_c;
    nx[8].mi1    = 6'(st[7].m60 - 11'(hr1_c) * 11'd60);
    nx[8].era400 = 14'(st[7].era) * 14'd400;

    // Stage 9: day of era folded onto 365-day years.
    nx[9]   = st[8];
    nx[9].a = 18'(19'(st[8].doe) - 19'(st[8].p1460[36:29]) + 19'(st[8].cent)
                  - 19'(st[8].lastd));

    // Stage 10: year of era.
    nx[10]      = st[9];
    nx[10].p365 = 37'(st[9].a) * 37'(UCC_RCP_365);

    // Stage 11: days before the year of era.
    nx[11]         = st[10];
    nx[11].yoe     = st[10].p365[35:27];
    nx[11].yoe365  = 18'(st[10].p365[35:27]) * 18'd365;
    nx[11].pyoe100 = 19'(st[10].p365[35:27]) * 19'(UCC_RCP_100_Y);

    // Stage 12: day of the March-based year.
    nx[12]     = st[11];
    nx[12].doy = 9'(18'(st[11].doe) - (st[11].yoe365 + 18'(st[11].yoe[8:2])
                    - 18'(st[11].pyoe100[18:16])));

    // Stage 13: month from the day of year.
    nx[13]     = st[12];
    nx[13].pmp = 23'(st[12].doy) * 23'(UCC_RCP_153_5) + 23'(UCC_RCP_153_2);

    // Stage 14: finish the date and select the result word by operation.
    nx[14] = st[13];
    mp     = st[13].pmp[22:19];
    day_c  = 5'(st[13].doy - ucc_mday_off(mp) + 9'd1);
    mon_c  = (mp >= 4'd10) ? 4'(mp - 4'd9) : 4'(mp + 4'd3);
    yr_c   = 14'(st[13].yoe) + st[13].era400 + 14'(mp >= 4'd10);
    nx[14].res.weekday = st[13].wday;
    if (st[13].op == UCC_OP_TO_SECONDS) begin
      nx[14].res.seconds_out  = st[13].secs0[38:0];
      nx[14].res.year_out     = st[13].yr;
      nx[14].res.month_out    = st[13].mo;
      nx[14].res.day_out      = st[13].dy;
      nx[14].res.hour_out     = st[13].hr;
      nx[14].res.minute_out   = st[13].mi;
      nx[14].res.second_out   = st[13].se;
      nx[14].res.out_of_range = st[13].oor0;
    end else begin
      nx[14].res.seconds_out  = st[13].secs_in;
      nx[14].res.year_out     = st[13].oor1 ? '0 : yr_c;
      nx[14].res.month_out    = st[13].oor1 ? '0 : mon_c;
      nx[14].res.day_out      = st[13].oor1 ? '0 : day_c;
      nx[14].res.hour_out     = st[13].hr1;
      nx[14].res.minute_out   = st[13].mi1;
      nx[14].res.second_out   = st[13].se1;
      nx[14].res.out_of_range = st[13].oor1;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < UCC_STAGES; k++) begin
      if (adv[k]) begin
        st[k] <= nx[k];
      end
    end
  end

  assign rsp = st[UCC_STAGES-1].res;

endmodule

// ----- tb/sv/ucc_checker.sv -----
// Checker for the Unix time calendar converter: predicts each result word and compares it.
`timescale 1ns / 1ps

module ucc_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_stall,
  input  logic               op,
  input  logic signed [38:0] epoch_seconds,
  input  logic [13:0]        year_in,
  input  logic [3:0]         month_in,
  input  logic [4:0]         day_in,
  input  logic [4:0]         hour_in,
  input  logic [5:0]         minute_in,
  input  logic [5:0]         second_in,
  input  logic               rsp_valid,
  input  logic               rsp_stall,
  input  logic signed [38:0] seconds_out,
  input  logic [13:0]        year_out,
  input  logic [3:0]         month_out,
  input  logic [4:0]         day_out,
  input  logic [4:0]         hour_out,
  input  logic [5:0]         minute_out,
  input  logic [5:0]         second_out,
  input  logic [2:0]         weekday,
  input  logic               out_of_range,
  output int                 mismatches,
  output int                 outstanding
);
  import ucc_pkg::*;

  localparam longint FIRST_SEC = -64'sd62135596800;
  localparam longint LAST_SEC  = 64'sd253402300799;
  localparam longint DAY_SECS  = 64'sd86400;
  localparam longint JD_EPOCH  = 64'sd2440588;

  ucc_rsp_t pending_rsp[$];

  function automatic ucc_rsp_t convert_time(input ucc_req_t w);
    ucc_rsp_t r;
    longint   secs, days, sod, yr, mo, dy, hr, mi, se;
    longint   early, yy, mm, jd, corr, shifted, q, doy, t, wd;
    bit       oor;
    yr = 0;
    mo = 0;
    dy = 0;
    if (w.op == UCC_OP_TO_SECONDS) begin
      yr = longint'(w.year_in);
      mo = longint'(w.month_in);
      dy = longint'(w.day_in);
      hr = longint'(w.hour_in);
      mi = longint'(w.minute_in);
      se = longint'(w.second_in);
      // Shift the year so it starts in March; division truncates as in C.
      early = (14 - mo) / 12;
      yy = yr + 4800 - early;
      mm = mo + 12 * early - 3;
      days = dy + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400
             - (32045 + JD_EPOCH);
      secs = days * DAY_SECS + hr * 3600 + mi * 60 + se;
    end else begin
      secs = {{25{w.epoch_seconds[38]}}, w.epoch_seconds};
      sod = secs % DAY_SECS;
      if (sod < 0) sod += DAY_SECS;
      days = (secs - sod) / DAY_SECS;
      hr = sod / 3600;
      mi = (sod / 60) % 60;
      se = sod % 60;
    end
    oor = (secs < FIRST_SEC) || (secs > LAST_SEC);
    if (w.op == UCC_OP_TO_CALENDAR && !oor) begin
      jd = days + JD_EPOCH;
      corr = (3 * ((4 * jd + 274277) / 146097)) / 4 - 38;
      shifted = jd + 1401 + corr;
      q = 4 * shifted + 3;
      doy = (q % 1461) / 4;
      t = 5 * doy + 2;
      dy = (t % 153) / 5 + 1;
      mo = ((t / 153 + 2) % 12) + 1;
      yr = q / 1461 - 4716 + (14 - mo) / 12;
    end
    // 1970-01-01 was a Thursday; floor the remainder.
    wd = (days + 3) % 7;
    if (wd < 0) wd += 7;
    r.seconds_out  = secs[38:0];
    r.year_out     = yr[13:0];
    r.month_out    = mo[3:0];
    r.day_out      = dy[4:0];
    r.hour_out     = hr[4:0];
    r.minute_out   = mi[5:0];
    r.second_out   = se[5:0];
    r.weekday      = wd[2:0];
    r.out_of_range = oor;
    return r;
  endfunction

  function automatic int field_bad(input string name, input longint want, input longint got);
    if (want == got) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    ucc_req_t w;
    ucc_rsp_t want;
    int       bad;
    bad = 0;
    if (rst) begin
      pending_rsp.delete();
      mismatches <= 0;
      outstanding <= 0;
    end else begin
      if (req_valid && !req_stall) begin
        w.op            = ucc_op_t'(op);
        w.epoch_seconds = epoch_seconds;
        w.year_in       = year_in;
        w.month_in      = month_in;
        w.day_in        = day_in;
        w.hour_in       = hour_in;
        w.minute_in     = minute_in;
        w.second_in     = second_in;
        pending_rsp.push_back(convert_time(w));
      end
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          $error("result word with no request waiting");
          bad = 1;
        end else begin
          want = pending_rsp.pop_front();
          bad += field_bad("seconds_out", longint'(want.seconds_out), longint'(seconds_out));
          bad += field_bad("year_out", want.year_out, year_out);
          bad += field_bad("month_out", want.month_out, month_out);
          bad += field_bad("day_out", want.day_out, day_out);
          bad += field_bad("hour_out", want.hour_out, hour_out);
          bad += field_bad("minute_out", want.minute_out, minute_out);
          bad += field_bad("second_out", want.second_out, second_out);
          bad += field_bad("weekday", want.weekday, weekday);
          bad += field_bad("out_of_range", want.out_of_range, out_of_range);
        end
      end
      mismatches <= mismatches + bad;
      outstanding <= pending_rsp.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top for the Unix time calendar converter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import ucc_pkg::*;

  // Roughly 900 words at about half throughput; the limit leaves plenty of room.
  localparam int     CYCLE_LIMIT  = 200000;
  localparam int     RANDOM_WORDS = 850;
  localparam longint FIRST_SEC    = -64'sd62135596800;
  localparam longint LAST_SEC     = 64'sd253402300799;
  localparam longint SEC_SPAN     = 64'sd315537897600;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic               op = 1'b0;
  logic signed [38:0] epoch_seconds = '0;
  logic [13:0]        year_in = '0;
  logic [3:0]         month_in = '0;
  logic [4:0]         day_in = '0;
  logic [4:0]         hour_in = '0;
  logic [5:0]         minute_in = '0;
  logic [5:0]         second_in = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic signed [38:0] seconds_out;
  logic [13:0]        year_out;
  logic [3:0]         month_out;
  logic [4:0]         day_out;
  logic [4:0]         hour_out;
  logic [5:0]         minute_out;
  logic [5:0]         second_out;
  logic [2:0]         weekday;
  logic               out_of_range;

  // High during the stretch where neither side idles.
  logic               steady = 1'b0;
  int                 mismatches;
  int                 outstanding;
  int unsigned        cycles = 0;

  always #1 clk = ~clk;

  unix_time_calendar_converter_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .op            (op),
    .epoch_seconds (epoch_seconds),
    .year_in       (year_in),
    .month_in      (month_in),
    .day_in        (day_in),
    .hour_in       (hour_in),
    .minute_in     (minute_in),
    .second_in     (second_in),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .seconds_out   (seconds_out),
    .year_out      (year_out),
    .month_out     (month_out),
    .day_out       (day_out),
    .hour_out      (hour_out),
    .minute_out    (minute_out),
    .second_out    (second_out),
    .weekday       (weekday),
    .out_of_range  (out_of_range)
  );

  ucc_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .op            (op),
    .epoch_seconds (epoch_seconds),
    .year_in       (year_in),
    .month_in      (month_in),
    .day_in        (day_in),
    .hour_in       (hour_in),
    .minute_in     (minute_in),
    .second_in     (second_in),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .seconds_out   (seconds_out),
    .year_out      (year_out),
    .month_out     (month_out),
    .day_out       (day_out),
    .hour_out      (hour_out),
    .minute_out    (minute_out),
    .second_out    (second_out),
    .weekday       (weekday),
    .out_of_range  (out_of_range),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // Stall the response side at random, about 30 percent of the time, never in the steady stretch.
  always @(posedge clk) begin
    rsp_stall <= !steady && ($urandom_range(99) < 30);
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** unix_time_calendar_converter_core: FAILED **");
      $finish;
    end
  end

  // Present one word and hold it until the converter takes it. Random idle
  // cycles go in front, so gaps land at every phase of the pipeline.
  task automatic send_word(input ucc_req_t w);
    while (!steady && $urandom_range(99) < 30) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid     <= 1'b1;
    op            <= w.op;
    epoch_seconds <= w.epoch_seconds;
    year_in       <= w.year_in;
    month_in      <= w.month_in;
    day_in        <= w.day_in;
    hour_in       <= w.hour_in;
    minute_in     <= w.minute_in;
    second_in     <= w.second_in;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Calendar fields to seconds; the unused seconds field carries noise.
  task automatic to_seconds(input int y, input int mo, input int d,
                            input int h, input int mi, input int s);
    ucc_req_t w;
    w.op            = UCC_OP_TO_SECONDS;
    w.epoch_seconds = 39'({$urandom, $urandom});
    w.year_in       = 14'(y);
    w.month_in      = 4'(mo);
    w.day_in        = 5'(d);
    w.hour_in       = 5'(h);
    w.minute_in     = 6'(mi);
    w.second_in     = 6'(s);
    send_word(w);
  endtask

  // Seconds to calendar fields; the unused date fields carry noise.
  task automatic to_calendar(input logic signed [38:0] secs);
    ucc_req_t w;
    w.op            = UCC_OP_TO_CALENDAR;
    w.epoch_seconds = secs;
    w.year_in       = 14'($urandom);
    w.month_in      = 4'($urandom);
    w.day_in        = 5'($urandom);
    w.hour_in       = 5'($urandom);
    w.minute_in     = 6'($urandom);
    w.second_in     = 6'($urandom);
    send_word(w);
  endtask

  initial begin
    longint base;
    int     yr;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: the epoch, both ends of the valid range and one step past
    // each, leap days, and unchecked fields that carry into their neighbors.
    to_seconds(1970, 1, 1, 0, 0, 0);
    to_seconds(1, 1, 1, 0, 0, 0);
    to_seconds(9999, 12, 31, 23, 59, 59);
    to_seconds(9999, 12, 31, 23, 59, 60);
    to_seconds(0, 12, 31, 23, 59, 59);
    to_seconds(0, 0, 0, 0, 0, 0);
    to_seconds(16383, 15, 31, 31, 63, 63);   // every field at all ones: wraps
    to_seconds(2000, 2, 29, 12, 30, 45);
    to_seconds(1900, 2, 29, 0, 0, 0);        // not a leap year, day carries
    to_seconds(2023, 13, 0, 24, 60, 60);
    to_seconds(2024, 0, 31, 0, 0, 0);
    to_calendar(39'sd0);
    to_calendar(-39'sd1);
    to_calendar(39'sd86399);
    to_calendar(-39'sd86400);
    to_calendar(-39'sd86401);
    to_calendar(39'(FIRST_SEC));
    to_calendar(39'(FIRST_SEC - 1));
    to_calendar(39'(LAST_SEC));
    to_calendar(39'(LAST_SEC + 1));
    to_calendar(39'sd951782400);             // 2000-02-29
    to_calendar(39'sd68169600);              // 1972-02-29
    to_calendar({1'b1, 38'd0});
    to_calendar({1'b0, {38{1'b1}}});

    // Random: mostly well-formed words, with boundary clusters and raw noise.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      steady <= (i >= 400) && (i < 550);
      if ($urandom_range(1) == 1) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: begin
            to_calendar(39'(longint'({$urandom, $urandom} % 64'(SEC_SPAN)) + FIRST_SEC));
          end
          6, 7: begin
            case ($urandom_range(4))
              0:       base = FIRST_SEC;
              1:       base = LAST_SEC + 1;
              2:       base = 0;
              3:       base = 64'sd951782400;
              default: base = -64'sd2208988800;   // 1900-01-01
            endcase
            to_calendar(39'(base + longint'($urandom_range(200000)) - 100000));
          end
          8: begin
            // Land on or next to a midnight.
            base = longint'($urandom_range(2000000)) * 86400 - 64'sd86400000000;
            to_calendar(39'(base + int'($urandom_range(4)) - 2));
          end
          default: begin
            to_calendar(39'({$urandom, $urandom}));
          end
        endcase
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: begin
            to_seconds($urandom_range(1, 9999), $urandom_range(1, 12), $urandom_range(1, 31),
                       $urandom_range(23), $urandom_range(59), $urandom_range(59));
          end
          6, 7: begin
            yr = ($urandom_range(1) == 1) ? $urandom_range(3) : 9998 + $urandom_range(3);
            to_seconds(yr, $urandom_range(1, 12), $urandom_range(1, 31),
                       $urandom_range(23), $urandom_range(59), $urandom_range(59));
          end
          default: begin
            to_seconds($urandom_range(16383), $urandom_range(15), $urandom_range(31),
                       $urandom_range(31), $urandom_range(63), $urandom_range(63));
          end
        endcase
      end
    end
    req_valid <= 1'b0;
    steady <= 1'b0;

    // Drain: wait for every result, then let the pipeline run dry.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (UCC_STAGES + 5) @(posedge clk);

    if (mismatches == 0) begin
      $display("** unix_time_calendar_converter_core: PASSED **");
    end else begin
      $display("** unix_time_calendar_converter_core: FAILED **");
    end
    $finish;
  end

endmodule
